@@ src/ccb_pkg.sv @@
package ccb_pkg;

    // Widths of the map and of one character.
    localparam int unsigned CharW  = 8;
    localparam int unsigned MapW   = 256;

    // Action codes of an input word.
    typedef enum logic [1:0] {
        ACT_SPEC = 2'd0,
        ACT_END  = 2'd1,
        ACT_TEST = 2'd2
    } t_action;

    // Parse state: IDLE means no spec is open.
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_FIRST   = 3'd1,
        PH_NORMAL  = 3'd2,
        PH_RANGE   = 3'd3,
        PH_SPECIAL = 3'd4
    } t_phase;

    // Map update operations requested by the controller.
    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_SET_LIT   = 3'd1,
        OP_RANGE     = 3'd2,
        OP_SPECIAL   = 3'd3,
        OP_SET_DASH  = 3'd4,
        OP_SET_TILDE = 3'd5,
        OP_FINISH    = 3'd6
    } t_map_op;

    // Character codes with a meaning in the spec syntax.
    localparam logic [CharW-1:0] CH_NUL   = 8'h00;
    localparam logic [CharW-1:0] CH_TAB   = 8'h09;
    localparam logic [CharW-1:0] CH_LF    = 8'h0A;
    localparam logic [CharW-1:0] CH_CR    = 8'h0D;
    localparam logic [CharW-1:0] CH_SPACE = 8'h20;
    localparam logic [CharW-1:0] CH_BANG  = 8'h21;
    localparam logic [CharW-1:0] CH_DASH  = 8'h2D;
    localparam logic [CharW-1:0] CH_0     = 8'h30;
    localparam logic [CharW-1:0] CH_9     = 8'h39;
    localparam logic [CharW-1:0] CH_UP_A  = 8'h41;
    localparam logic [CharW-1:0] CH_UP_D  = 8'h44;
    localparam logic [CharW-1:0] CH_UP_L  = 8'h4C;
    localparam logic [CharW-1:0] CH_UP_S  = 8'h53;
    localparam logic [CharW-1:0] CH_UP_W  = 8'h57;
    localparam logic [CharW-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CharW-1:0] CH_BSL   = 8'h5C;
    localparam logic [CharW-1:0] CH_CARET = 8'h5E;
    localparam logic [CharW-1:0] CH_UNDER = 8'h5F;
    localparam logic [CharW-1:0] CH_LO_A  = 8'h61;
    localparam logic [CharW-1:0] CH_LO_D  = 8'h64;
    localparam logic [CharW-1:0] CH_LO_L  = 8'h6C;
    localparam logic [CharW-1:0] CH_LO_N  = 8'h6E;
    localparam logic [CharW-1:0] CH_LO_R  = 8'h72;
    localparam logic [CharW-1:0] CH_LO_S  = 8'h73;
    localparam logic [CharW-1:0] CH_LO_T  = 8'h74;
    localparam logic [CharW-1:0] CH_LO_U  = 8'h75;
    localparam logic [CharW-1:0] CH_LO_W  = 8'h77;
    localparam logic [CharW-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [CharW-1:0] CH_TILDE = 8'h7E;
    localparam logic [CharW-1:0] CH_MAX   = 8'hFF;

    // Input and result words.
    typedef struct packed {
        logic [1:0]       action;
        logic [CharW-1:0] char_code;
    } t_in_word;

    typedef struct packed {
        logic matched;
        logic class_ready;
    } t_out_word;

    // Classification of the incoming byte, datapath to controller.
    typedef struct packed {
        logic is_zero;
        logic is_caret;
        logic is_dash;
        logic is_intro;
    } t_byte_status;

    // Command from controller to datapath.
    typedef struct packed {
        logic    en;
        logic    clr;
        t_map_op op;
        logic    invert;
        logic    test;
        logic    class_ready;
    } t_dp_cmd;

    // Set of codes from lo to hi inclusive; empty when hi is below lo.
    function automatic logic [MapW-1:0] range_mask(logic [CharW-1:0] lo,
                                                   logic [CharW-1:0] hi);
        logic [MapW-1:0] m;
        for (int i = 0; i < MapW; i++) begin
            m[i] = (CharW'(i) >= lo) && (CharW'(i) <= hi);
        end
        return m;
    endfunction

    function automatic logic [MapW-1:0] bit_mask(logic [CharW-1:0] c);
        return MapW'(1) << c;
    endfunction

    localparam logic [MapW-1:0] MaskLetter = range_mask(CH_LO_A, CH_LO_Z)
                                           | range_mask(CH_UP_A, CH_UP_Z);
    localparam logic [MapW-1:0] MaskDigit  = range_mask(CH_0, CH_9);
    localparam logic [MapW-1:0] MaskWord   = MaskLetter | MaskDigit
                                           | bit_mask(CH_UNDER);
    localparam logic [MapW-1:0] MaskSpace  = bit_mask(CH_SPACE) | bit_mask(CH_TAB)
                                           | bit_mask(CH_CR) | bit_mask(CH_LF);
    localparam logic [MapW-1:0] MaskUpper  = range_mask(CH_BANG, CH_MAX);

    // Set added by the byte that follows a special introducer.
    function automatic logic [MapW-1:0] special_mask(logic [CharW-1:0] b);
        logic [MapW-1:0] m;
        case (b)
            CH_LO_W: m = MaskWord;
            CH_LO_D: m = MaskDigit;
            CH_LO_S: m = MaskSpace;
            CH_LO_L: m = MaskLetter;
            CH_UP_W: m = ~MaskWord;
            CH_UP_D: m = ~MaskDigit;
            CH_UP_S: m = ~MaskSpace;
            CH_UP_L: m = ~MaskLetter;
            CH_LO_U: m = MaskUpper;
            CH_LO_T: m = bit_mask(CH_TAB);
            CH_LO_R: m = bit_mask(CH_CR);
            CH_LO_N: m = bit_mask(CH_LF);
            default: m = bit_mask(b);
        endcase
        return m;
    endfunction

endpackage

@@ src/ccb_dpath.sv @@
module ccb_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_char,
    input  ccb_pkg::t_dp_cmd    i_cmd,
    output ccb_pkg::t_byte_status o_status,
    output ccb_pkg::t_out_word  o_word
);

    logic [ccb_pkg::MapW-1:0]  r_map;
    logic [ccb_pkg::MapW-1:0]  n_map;
    logic [ccb_pkg::CharW-1:0] r_last;
    logic [ccb_pkg::CharW-1:0] n_last;
    logic [ccb_pkg::MapW-1:0]  base_map;
    logic [ccb_pkg::MapW-1:0]  fin_map;
    ccb_pkg::t_out_word        r_word;

    // Classify the byte for the controller.
    always_comb begin
        o_status.is_zero  = (i_char == ccb_pkg::CH_NUL);
        o_status.is_caret = (i_char == ccb_pkg::CH_CARET);
        o_status.is_dash  = (i_char == ccb_pkg::CH_DASH);
        o_status.is_intro = (i_char == ccb_pkg::CH_BSL) || (i_char == ccb_pkg::CH_TILDE);
    end

    // Next map: optional clear of a new spec, then one mask operation.
    always_comb begin
        base_map = i_cmd.clr ? '0 : r_map;
        fin_map  = i_cmd.invert ? ~base_map : base_map;
        fin_map[0] = 1'b0;
        case (i_cmd.op)
            ccb_pkg::OP_SET_LIT:   n_map = base_map | ccb_pkg::bit_mask(i_char);
            ccb_pkg::OP_RANGE:     n_map = base_map | ccb_pkg::range_mask(r_last, i_char);
            ccb_pkg::OP_SPECIAL:   n_map = base_map | ccb_pkg::special_mask(i_char);
            ccb_pkg::OP_SET_DASH:  n_map = base_map | ccb_pkg::bit_mask(ccb_pkg::CH_DASH);
            ccb_pkg::OP_SET_TILDE: n_map = base_map | ccb_pkg::bit_mask(ccb_pkg::CH_TILDE);
            ccb_pkg::OP_FINISH:    n_map = fin_map;
            default:               n_map = base_map;
        endcase
    end

    // Only plain literals move the range start; a new spec resets it.
    always_comb begin
        if (i_cmd.op == ccb_pkg::OP_SET_LIT) begin
            n_last = i_char;
        end else if (i_cmd.clr) begin
            n_last = ccb_pkg::CH_MAX;
        end else begin
            n_last = r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map  <= '0;
            r_last <= ccb_pkg::CH_MAX;
        end else if (i_cmd.en) begin
            r_map  <= n_map;
            r_last <= n_last;
        end
    end

    // Result register; the map lookup uses the map before this word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            r_word.matched     <= i_cmd.test & r_map[i_char];
            r_word.class_ready <= i_cmd.class_ready;
        end
    end

    assign o_word = r_word;

endmodule

@@ src/ccb_ctrl.sv @@
module ccb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [1:0]            i_action,
    input  ccb_pkg::t_byte_status i_status,
    input  logic                  i_out_ready,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output ccb_pkg::t_dp_cmd      o_cmd
);

    ccb_pkg::t_phase r_state;
    ccb_pkg::t_phase n_state;
    logic            r_invert;
    logic            n_invert;
    logic            r_out_valid;
    logic            fire;
    logic            is_byte;
    logic            is_close;
    logic            is_test;

    // A word is taken whenever the result slot is free or being emptied.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign fire        = i_in_valid && o_in_ready;

    assign is_byte  = (i_action == ccb_pkg::ACT_SPEC) && !i_status.is_zero;
    assign is_close = (i_action == ccb_pkg::ACT_END)
                   || ((i_action == ccb_pkg::ACT_SPEC) && i_status.is_zero);
    assign is_test  = (i_action == ccb_pkg::ACT_TEST);

    // Next state of the parser.
    always_comb begin
        n_state  = r_state;
        n_invert = r_invert;
        if (fire && is_close) begin
            n_state  = ccb_pkg::PH_IDLE;
            n_invert = 1'b0;
        end else if (fire && is_byte) begin
            case (r_state)
                ccb_pkg::PH_RANGE, ccb_pkg::PH_SPECIAL: begin
                    n_state = ccb_pkg::PH_NORMAL;
                end
                default: begin
                    if ((r_state == ccb_pkg::PH_IDLE || r_state == ccb_pkg::PH_FIRST)
                        && i_status.is_caret) begin
                        n_state  = ccb_pkg::PH_NORMAL;
                        n_invert = 1'b1;
                    end else if (i_status.is_dash) begin
                        n_state = ccb_pkg::PH_RANGE;
                    end else if (i_status.is_intro) begin
                        n_state = ccb_pkg::PH_SPECIAL;
                    end else begin
                        n_state = ccb_pkg::PH_NORMAL;
                    end
                    if (r_state == ccb_pkg::PH_IDLE && !i_status.is_caret) begin
                        n_invert = 1'b0;
                    end
                end
            endcase
        end
    end

    // Datapath command for the word being taken.
    always_comb begin
        o_cmd.en          = fire;
        o_cmd.clr         = 1'b0;
        o_cmd.op          = ccb_pkg::OP_NONE;
        o_cmd.invert      = 1'b0;
        o_cmd.test        = is_test && (r_state == ccb_pkg::PH_IDLE);
        o_cmd.class_ready = (n_state == ccb_pkg::PH_IDLE);
        if (is_close) begin
            case (r_state)
                ccb_pkg::PH_IDLE: begin
                    o_cmd.clr = 1'b1;
                    o_cmd.op  = ccb_pkg::OP_FINISH;
                end
                ccb_pkg::PH_RANGE:   o_cmd.op = ccb_pkg::OP_SET_DASH;
                ccb_pkg::PH_SPECIAL: o_cmd.op = ccb_pkg::OP_SET_TILDE;
                default: begin
                    o_cmd.op     = ccb_pkg::OP_FINISH;
                    o_cmd.invert = r_invert;
                end
            endcase
        end else if (is_byte) begin
            o_cmd.clr = (r_state == ccb_pkg::PH_IDLE);
            case (r_state)
                ccb_pkg::PH_RANGE:   o_cmd.op = ccb_pkg::OP_RANGE;
                ccb_pkg::PH_SPECIAL: o_cmd.op = ccb_pkg::OP_SPECIAL;
                default: begin
                    if ((r_state == ccb_pkg::PH_IDLE || r_state == ccb_pkg::PH_FIRST)
                        && i_status.is_caret) begin
                        o_cmd.op = ccb_pkg::OP_NONE;
                    end else if (i_status.is_dash || i_status.is_intro) begin
                        o_cmd.op = ccb_pkg::OP_NONE;
                    end else begin
                        o_cmd.op = ccb_pkg::OP_SET_LIT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ccb_pkg::PH_IDLE;
            r_invert    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_invert <= n_invert;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Closing a spec always leaves the parser idle.
    a_close_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && is_close) |=> (r_state == ccb_pkg::PH_IDLE))
        else $error("parser not idle after close");

    // A nonzero spec byte always leaves a spec open.
    a_byte_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && is_byte) |=> (r_state != ccb_pkg::PH_IDLE))
        else $error("spec not open after spec byte");

    // Inversion is only pending inside an open spec.
    a_invert_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_invert |-> (r_state != ccb_pkg::PH_IDLE))
        else $error("inversion pending with no open spec");

    // A word taken always produces a result on the next cycle.
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("accepted word produced no result");

endmodule

@@ src/char_class_bitmap_compiler.sv @@
// Channel  Direction  Handshake                     Payload
// in       input      i_in_valid / o_in_ready       i_in_word  (action, char_code)
// out      output     o_out_valid / i_out_ready     o_out_word (matched, class_ready)
//
// The whole map update of a word is a single mask operation
// on a 256-bit flop map, and the result lands in a one-deep output register.
// A new word is taken whenever that register is empty or is read in the same cycle.
// Synchronous active-low reset empties the map and leaves no spec open.
// A stalled output holds its word and blocks input until it is taken.
module char_class_bitmap_compiler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ccb_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ccb_pkg::t_out_word o_out_word
);

    ccb_pkg::t_dp_cmd     cmd;
    ccb_pkg::t_byte_status status;

    // Parser control and handshake.
    ccb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_in_word.action),
        .i_status    (status),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Membership map and result register.
    ccb_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (i_in_word.char_code),
        .i_cmd    (cmd),
        .o_status (status),
        .o_word   (o_out_word)
    );

endmodule

@@ verif/tb_char_class_bitmap_compiler.sv @@
module tb_char_class_bitmap_compiler;

    timeunit 1ns;
    timeprecision 1ps;

    // Action code that the block must ignore; the package gives it no name.
    localparam logic [1:0] ActUnused  = 2'd3;
    localparam int         CycleLimit = 200000;
    localparam int         RandomWords = 1030;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    ccb_pkg::t_in_word  in_word   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    ccb_pkg::t_out_word out_word;

    // Expected result words, oldest first.
    ccb_pkg::t_out_word expected_results[$];
    int        errors      = 0;
    int        words_sent  = 0;
    int        cycle_count = 0;
    int        burst_left  = 0;

    // Shadow copy of the class compiler state.
    logic [ccb_pkg::MapW-1:0]  cls_map    = '0;
    logic [ccb_pkg::CharW-1:0] lit_prev   = ccb_pkg::CH_MAX;
    ccb_pkg::t_phase           cls_phase  = ccb_pkg::PH_IDLE;
    logic                      cls_invert = 1'b0;

    char_class_bitmap_compiler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Set of codes lo..hi; empty when the range is reversed.
    function automatic logic [ccb_pkg::MapW-1:0] span(logic [ccb_pkg::CharW-1:0] lo,
                                                      logic [ccb_pkg::CharW-1:0] hi);
        logic [ccb_pkg::MapW-1:0] m;
        m = '0;
        for (int i = lo; i <= hi; i++) begin
            m[i] = 1'b1;
        end
        return m;
    endfunction

    // Set added by the byte that follows a special introducer.
    function automatic logic [ccb_pkg::MapW-1:0] special_set(logic [ccb_pkg::CharW-1:0] b);
        logic [ccb_pkg::MapW-1:0] letters;
        logic [ccb_pkg::MapW-1:0] digits;
        logic [ccb_pkg::MapW-1:0] words;
        logic [ccb_pkg::MapW-1:0] spaces;
        logic [ccb_pkg::MapW-1:0] m;
        letters = span(ccb_pkg::CH_LO_A, ccb_pkg::CH_LO_Z)
                | span(ccb_pkg::CH_UP_A, ccb_pkg::CH_UP_Z);
        digits  = span(ccb_pkg::CH_0, ccb_pkg::CH_9);
        words   = letters | digits;
        words[ccb_pkg::CH_UNDER] = 1'b1;
        spaces  = '0;
        spaces[ccb_pkg::CH_SPACE] = 1'b1;
        spaces[ccb_pkg::CH_TAB]   = 1'b1;
        spaces[ccb_pkg::CH_CR]    = 1'b1;
        spaces[ccb_pkg::CH_LF]    = 1'b1;
        m = '0;
        case (b)
            ccb_pkg::CH_LO_W: m = words;
            ccb_pkg::CH_LO_D: m = digits;
            ccb_pkg::CH_LO_S: m = spaces;
            ccb_pkg::CH_LO_L: m = letters;
            ccb_pkg::CH_UP_W: m = ~words;
            ccb_pkg::CH_UP_D: m = ~digits;
            ccb_pkg::CH_UP_S: m = ~spaces;
            ccb_pkg::CH_UP_L: m = ~letters;
            ccb_pkg::CH_LO_U: m = span(ccb_pkg::CH_BANG, ccb_pkg::CH_MAX);
            ccb_pkg::CH_LO_T: m[ccb_pkg::CH_TAB] = 1'b1;
            ccb_pkg::CH_LO_R: m[ccb_pkg::CH_CR] = 1'b1;
            ccb_pkg::CH_LO_N: m[ccb_pkg::CH_LF] = 1'b1;
            default: m[b] = 1'b1;
        endcase
        return m;
    endfunction

    function automatic void spec_begin();
        cls_map    = '0;
        lit_prev   = ccb_pkg::CH_MAX;
        cls_phase  = ccb_pkg::PH_FIRST;
        cls_invert = 1'b0;
    endfunction

    // Closing right after a dash or an introducer skips inversion and bit 0 clearing.
    function automatic void spec_close();
        if (cls_phase == ccb_pkg::PH_IDLE) begin
            spec_begin();
        end
        if (cls_phase == ccb_pkg::PH_RANGE) begin
            cls_map[ccb_pkg::CH_DASH] = 1'b1;
        end else if (cls_phase == ccb_pkg::PH_SPECIAL) begin
            cls_map[ccb_pkg::CH_TILDE] = 1'b1;
        end else begin
            if (cls_invert) begin
                cls_map = ~cls_map;
            end
            cls_map[ccb_pkg::CH_NUL] = 1'b0;
        end
        cls_phase  = ccb_pkg::PH_IDLE;
        cls_invert = 1'b0;
    endfunction

    function automatic void spec_byte(logic [ccb_pkg::CharW-1:0] b);
        if (cls_phase == ccb_pkg::PH_IDLE) begin
            spec_begin();
        end
        case (cls_phase)
            ccb_pkg::PH_RANGE: begin
                cls_map   = cls_map | span(lit_prev, b);
                cls_phase = ccb_pkg::PH_NORMAL;
            end
            ccb_pkg::PH_SPECIAL: begin
                cls_map   = cls_map | special_set(b);
                cls_phase = ccb_pkg::PH_NORMAL;
            end
            default: begin
                if (cls_phase == ccb_pkg::PH_FIRST && b == ccb_pkg::CH_CARET) begin
                    cls_invert = 1'b1;
                    cls_phase  = ccb_pkg::PH_NORMAL;
                end else if (b == ccb_pkg::CH_DASH) begin
                    cls_phase = ccb_pkg::PH_RANGE;
                end else if (b == ccb_pkg::CH_BSL || b == ccb_pkg::CH_TILDE) begin
                    cls_phase = ccb_pkg::PH_SPECIAL;
                end else begin
                    cls_map[b] = 1'b1;
                    lit_prev   = b;
                    cls_phase  = ccb_pkg::PH_NORMAL;
                end
            end
        endcase
    endfunction

    // Applies one input word to the shadow state and returns the result word it causes.
    function automatic ccb_pkg::t_out_word class_step(ccb_pkg::t_in_word w);
        ccb_pkg::t_out_word r;
        r.matched = 1'b0;
        case (w.action)
            ccb_pkg::ACT_SPEC: begin
                if (w.char_code == ccb_pkg::CH_NUL) begin
                    spec_close();
                end else begin
                    spec_byte(w.char_code);
                end
            end
            ccb_pkg::ACT_END: spec_close();
            ccb_pkg::ACT_TEST: begin
                if (cls_phase == ccb_pkg::PH_IDLE) begin
                    r.matched = cls_map[w.char_code];
                end
            end
            default: ;
        endcase
        r.class_ready = (cls_phase == ccb_pkg::PH_IDLE);
        return r;
    endfunction

    // Sends one word; bursts of random length are separated by random gaps.
    task automatic send_word(logic [1:0] act, logic [ccb_pkg::CharW-1:0] code);
        ccb_pkg::t_in_word w;
        int                gap;
        w.action    = act;
        w.char_code = code;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word  <= w;
        do begin
            @(posedge clk);
        end while (!in_ready);
        expected_results.push_back(class_step(w));
        words_sent++;
    endtask

    task automatic send_spec(logic [ccb_pkg::CharW-1:0] code);
        send_word(ccb_pkg::ACT_SPEC, code);
    endtask

    // Holds the sender off until every expected result word has come back.
    task automatic wait_for_results();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // A nonzero byte that is parsed as a plain literal unless it is a caret at the start of a spec.
    function automatic logic [ccb_pkg::CharW-1:0] plain_byte();
        logic [ccb_pkg::CharW-1:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while (b == ccb_pkg::CH_DASH || b == ccb_pkg::CH_BSL || b == ccb_pkg::CH_TILDE);
        return b;
    endfunction

    function automatic logic [ccb_pkg::CharW-1:0] special_key();
        logic [ccb_pkg::CharW-1:0] keys [12];
        keys = '{ccb_pkg::CH_LO_W, ccb_pkg::CH_LO_D, ccb_pkg::CH_LO_S, ccb_pkg::CH_LO_L,
                 ccb_pkg::CH_UP_W, ccb_pkg::CH_UP_D, ccb_pkg::CH_UP_S, ccb_pkg::CH_UP_L,
                 ccb_pkg::CH_LO_U, ccb_pkg::CH_LO_T, ccb_pkg::CH_LO_R, ccb_pkg::CH_LO_N};
        if ($urandom_range(0, 4) == 0) begin
            return 8'($urandom_range(1, 255));
        end
        return keys[$urandom_range(0, 11)];
    endfunction

    // Result checker: every accepted result word is matched with the oldest expectation.
    always @(posedge clk) begin
        ccb_pkg::t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result word: matched %0b class_ready %0b",
                       out_word.matched, out_word.class_ready);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (out_word.matched !== want.matched) begin
                    $error("matched: expected %0b, actual %0b", want.matched, out_word.matched);
                    errors++;
                end
                if (out_word.class_ready !== want.class_ready) begin
                    $error("class_ready: expected %0b, actual %0b",
                           want.class_ready, out_word.class_ready);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls: modes of no stall, light stall and heavy stall take turns.
    int unsigned stall_mode = 0;
    int unsigned mode_left  = 0;
    always @(posedge clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 2) == 0);
        endcase
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The empty map after reset is a ready class; the unused action changes nothing.
    task automatic test_reset_state();
        send_word(ccb_pkg::ACT_TEST, ccb_pkg::CH_NUL);
        send_word(ccb_pkg::ACT_TEST, ccb_pkg::CH_MAX);
        send_word(ActUnused, ccb_pkg::CH_UP_A);
    endtask

    // Leading caret, range from the initial last literal, a complement set,
    // a reversed range, a later caret and a test while the spec is open.
    task automatic test_compile_extremes();
        send_spec(ccb_pkg::CH_CARET);
        send_spec(ccb_pkg::CH_DASH);
        send_spec(ccb_pkg::CH_MAX);
        send_spec(ccb_pkg::CH_LO_A);
        send_spec(ccb_pkg::CH_BSL);
        send_spec(ccb_pkg::CH_UP_W);
        send_spec(ccb_pkg::CH_LO_Z);
        send_spec(ccb_pkg::CH_DASH);
        send_spec(ccb_pkg::CH_LO_A);
        send_spec(ccb_pkg::CH_CARET);
        send_word(ccb_pkg::ACT_TEST, ccb_pkg::CH_LO_A);
        send_word(ccb_pkg::ACT_END, ccb_pkg::CH_NUL);
        send_word(ccb_pkg::ACT_TEST, ccb_pkg::CH_NUL);
        send_word(ccb_pkg::ACT_TEST, ccb_pkg::CH_LO_D);
        send_word(ccb_pkg::ACT_TEST, ccb_pkg::CH_MAX);
    endtask

    // Closing after a dash or an introducer, a zero byte as close, and a close
    // with no spec open.
    task automatic test_dangling_close();
        send_spec(ccb_pkg::CH_DASH);
        send_spec(ccb_pkg::CH_NUL);
        send_word(ccb_pkg::ACT_TEST, ccb_pkg::CH_DASH);
        send_spec(ccb_pkg::CH_TILDE);
        send_word(ccb_pkg::ACT_END, ccb_pkg::CH_MAX);
        send_word(ccb_pkg::ACT_TEST, ccb_pkg::CH_TILDE);
        send_word(ccb_pkg::ACT_END, ccb_pkg::CH_NUL);
        send_word(ccb_pkg::ACT_TEST, ccb_pkg::CH_TILDE);
    endtask

    // One well-formed spec with random content, closed and then probed.
    task automatic send_random_spec();
        int                        n;
        logic [ccb_pkg::CharW-1:0] lo;
        if ($urandom_range(0, 3) == 0) begin
            send_spec(ccb_pkg::CH_CARET);
        end
        n = $urandom_range(0, 6);
        repeat (n) begin
            case ($urandom_range(0, 2))
                0: send_spec(plain_byte());
                1: begin
                    lo = plain_byte();
                    send_spec(lo);
                    send_spec(ccb_pkg::CH_DASH);
                    if ($urandom_range(0, 1) == 0 && lo < ccb_pkg::CH_MAX - 8'd40) begin
                        send_spec(lo + 8'($urandom_range(0, 40)));
                    end else begin
                        send_spec(8'($urandom_range(1, 255)));
                    end
                end
                default: begin
                    send_spec(($urandom_range(0, 1) == 0) ? ccb_pkg::CH_BSL
                                                          : ccb_pkg::CH_TILDE);
                    send_spec(special_key());
                end
            endcase
        end
        if ($urandom_range(0, 4) == 0) begin
            send_spec(ccb_pkg::CH_NUL);
        end else begin
            send_word(ccb_pkg::ACT_END, 8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(1, 6)) begin
            send_word(ccb_pkg::ACT_TEST, 8'($urandom_range(0, 255)));
        end
    endtask

    // Noise words and broken specs.
    task automatic send_broken();
        case ($urandom_range(0, 3))
            0: send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            1: begin
                send_spec(ccb_pkg::CH_DASH);
                send_word(ccb_pkg::ACT_END, 8'($urandom_range(0, 255)));
            end
            2: begin
                send_spec(($urandom_range(0, 1) == 0) ? ccb_pkg::CH_BSL
                                                      : ccb_pkg::CH_TILDE);
                send_spec(ccb_pkg::CH_NUL);
            end
            default: begin
                send_spec(plain_byte());
                send_word(ccb_pkg::ACT_TEST, 8'($urandom_range(0, 255)));
                send_word(ActUnused, 8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic test_random_specs();
        int target;
        int pause_at;
        target   = words_sent + RandomWords;
        pause_at = words_sent + RandomWords / 2;
        while (words_sent < target) begin
            if ($urandom_range(0, 9) < 8) begin
                send_random_spec();
            end else begin
                send_broken();
            end
            if (pause_at != 0 && words_sent >= pause_at) begin
                wait_for_results();
                pause_at = 0;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_compile_extremes();
        wait_for_results();
        test_dangling_close();
        test_random_specs();

        wait_for_results();
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected result words never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/ccb_pkg.sv
src/ccb_dpath.sv
src/ccb_ctrl.sv
src/char_class_bitmap_compiler.sv
verif/tb_char_class_bitmap_compiler.sv
